@@ rtl/core/lpd_pkg.sv @@
// Shared constants and types for the length-prefixed deframer.
package lpd_pkg;

    // Header layout in bytes
    localparam logic [4:0] HEADER_BYTES = 5'd20;
    localparam logic [4:0] LENGTH_BYTES = 5'd4;
    localparam logic [4:0] SECONDS_END  = 5'd12;

    // Reset value of the max_length register
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd2048;

    // Result kind codes
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] frame_length;
        logic [63:0] stamp_seconds;
        logic [63:0] stamp_nanoseconds;
        logic [7:0]  data_byte;
        logic        last_of_frame;
    } t_result;

endpackage

@@ rtl/core/lpd_in_reg.sv @@
// Input register stage: holds one received byte until the parser takes it.
module lpd_in_reg import lpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Take a new item when empty or when the held item moves on
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold the byte; no reset needed on payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

@@ rtl/core/lpd_parser.sv @@
// Deframing state: header shift registers, payload counter and length limit.
module lpd_parser import lpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    output logic        o_res_valid,
    output t_result     o_result
);

    logic [15:0] r_max_length;
    logic [4:0]  r_header_count, n_header_count;
    logic [31:0] r_length, n_length;
    logic [63:0] r_seconds, n_seconds;
    logic [63:0] r_nanos, n_nanos;
    logic [31:0] r_payload_count, n_payload_count;
    logic        r_skipping, n_skipping;

    // Decode one byte against the current state
    always_comb begin
        n_header_count  = r_header_count;
        n_length        = r_length;
        n_seconds       = r_seconds;
        n_nanos         = r_nanos;
        n_payload_count = r_payload_count;
        n_skipping      = r_skipping;
        o_res_valid     = 1'b0;
        o_result.kind   = KIND_HEADER;
        o_result.last_of_frame = 1'b0;
        o_result.data_byte     = 8'd0;

        if (r_header_count < HEADER_BYTES) begin
            // Shift the header byte into its field
            if (r_header_count < LENGTH_BYTES) begin
                n_length = {r_length[23:0], i_byte};
            end else if (r_header_count < SECONDS_END) begin
                n_seconds = {r_seconds[55:0], i_byte};
            end else begin
                n_nanos = {r_nanos[55:0], i_byte};
            end
            n_header_count = r_header_count + 5'd1;
            if (n_header_count == HEADER_BYTES) begin
                n_payload_count = 32'd0;
                o_res_valid     = 1'b1;
                if (n_length > {16'd0, r_max_length}) begin
                    // Oversize: flag it and drop the declared payload
                    n_skipping    = 1'b1;
                    o_result.kind = KIND_ERROR;
                end else begin
                    n_skipping    = 1'b0;
                    o_result.kind = KIND_HEADER;
                    if (n_length == 32'd0) begin
                        // Empty frame ends at its header
                        n_header_count         = 5'd0;
                        o_result.last_of_frame = 1'b1;
                    end
                end
            end
        end else begin
            // Payload byte: pass it on unless skipping
            n_payload_count        = r_payload_count + 32'd1;
            o_result.kind          = KIND_PAYLOAD;
            o_result.data_byte     = i_byte;
            o_res_valid            = !r_skipping;
            if (n_payload_count >= r_length) begin
                n_header_count         = 5'd0;
                n_skipping             = 1'b0;
                o_result.last_of_frame = 1'b1;
            end
        end

        o_result.frame_length      = n_length;
        o_result.stamp_seconds     = n_seconds;
        o_result.stamp_nanoseconds = n_nanos;
    end

    // Advance state when the input stage hands over an item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_count  <= 5'd0;
            r_length        <= 32'd0;
            r_seconds       <= 64'd0;
            r_nanos         <= 64'd0;
            r_payload_count <= 32'd0;
            r_skipping      <= 1'b0;
        end else if (i_step) begin
            r_header_count  <= n_header_count;
            r_length        <= n_length;
            r_seconds       <= n_seconds;
            r_nanos         <= n_nanos;
            r_payload_count <= n_payload_count;
            r_skipping      <= n_skipping;
        end
    end

    // Length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_data;
        end
    end

endmodule

@@ rtl/core/lpd_out_reg.sv @@
// Result register stage: holds one result item until the receiver takes it.
module lpd_out_reg import lpd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_res_valid,
    input  t_result i_result,
    output logic    o_advance,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Free to load when empty or when the held item is taken
    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_step && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_step && i_res_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ rtl/core/length_prefixed_deframer_core.sv @@
// Top level of the length-prefixed deframer.
//
// Input channel (i_rx_valid / o_rx_ready / i_rx_byte) carries one link byte
// per item. Each frame is a 20-byte header (4-byte big-endian length, 8-byte
// seconds, 8-byte nanoseconds) followed by the payload.
// Result channel (o_res_valid / i_res_ready) gives a header item when the
// 20th header byte is in, then one item per payload byte, the final one with
// o_last_of_frame set. A zero length sets last on the header item. A length
// above max_length gives an error item and the payload is dropped silently.
// max_length is written through i_cfg_we / i_cfg_data and is sampled when a
// header completes.
// A byte passes through the input register, then the result register; the
// decode between the two registers is combinational. Throughput: one byte per
// clock while the receiver takes every result item.
// Reset (synchronous, active low) empties both stages, clears the frame
// state and sets max_length to 2048.
// When the receiver stalls, the result register holds and the input register
// takes a byte only if empty; o_rx_ready then stays low until the stall ends.
module length_prefixed_deframer_core import lpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_frame_length,
    output logic [63:0] o_stamp_seconds,
    output logic [63:0] o_stamp_nanoseconds,
    output logic [7:0]  o_data_byte,
    output logic        o_last_of_frame
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       advance;
    logic       step;
    logic       dec_valid;
    t_result    dec_result;
    t_result    out_result;

    // Move the held byte through the decoder when the result stage is free
    assign step = in_valid && advance;

    lpd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx_valid),
        .i_byte    (i_rx_byte),
        .o_ready   (o_rx_ready),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    lpd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_byte      (in_byte),
        .o_res_valid (dec_valid),
        .o_result    (dec_result)
    );

    lpd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_res_valid (dec_valid),
        .i_result    (dec_result),
        .o_advance   (advance),
        .o_valid     (o_res_valid),
        .i_ready     (i_res_ready),
        .o_result    (out_result)
    );

    // Unpack the result item onto its ports
    assign o_kind              = out_result.kind;
    assign o_frame_length      = out_result.frame_length;
    assign o_stamp_seconds     = out_result.stamp_seconds;
    assign o_stamp_nanoseconds = out_result.stamp_nanoseconds;
    assign o_data_byte         = out_result.data_byte;
    assign o_last_of_frame     = out_result.last_of_frame;

endmodule

@@ rtl/core/lpd_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
module lpd_checker import lpd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  o_kind,
    input logic [31:0] o_frame_length,
    input logic [7:0]  o_data_byte,
    input logic        o_last_of_frame
);

    // Hold a stalled result item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_kind)
            && $stable(o_data_byte) && $stable(o_last_of_frame))
        else $error("result item changed while stalled");

    // Header item ends the frame exactly when the length is zero
    a_hdr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_kind == KIND_HEADER |->
            o_last_of_frame == (o_frame_length == 32'd0))
        else $error("header last flag disagrees with length");

    // Error item carries a nonzero length and never ends a frame
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_kind == KIND_ERROR |->
            !o_last_of_frame && o_frame_length != 32'd0)
        else $error("bad error item");

    // Data byte is zero outside payload items
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_kind != KIND_PAYLOAD |-> o_data_byte == 8'd0)
        else $error("data byte set on non-payload item");

    // Payload items only appear for a nonzero length
    a_pay_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_kind == KIND_PAYLOAD |-> o_frame_length != 32'd0)
        else $error("payload item in empty frame");

endmodule

bind length_prefixed_deframer_core lpd_checker u_lpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_res_valid     (o_res_valid),
    .i_res_ready     (i_res_ready),
    .o_kind          (o_kind),
    .o_frame_length  (o_frame_length),
    .o_data_byte     (o_data_byte),
    .o_last_of_frame (o_last_of_frame)
);

@@ dv/lpd_checker.sv @@
// Checker for the length-prefixed deframer: tracks frame state and compares every result item.
module lpd_tb_checker import lpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_frame_length,
    input  logic [63:0] i_stamp_seconds,
    input  logic [63:0] i_stamp_nanoseconds,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_of_frame,
    output int          o_error_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // Deframer state as the block should hold it
    logic [15:0] limit_len;
    logic [4:0]  hdr_taken;
    logic [31:0] len_shift;
    logic [63:0] sec_shift;
    logic [63:0] nsec_shift;
    logic [31:0] body_taken;
    logic        dropping;

    t_result expected_results[$];
    int      error_count = 0;

    // Advance the frame state by one link byte and queue the item it causes
    function automatic void deframe_byte(input logic [7:0] b);
        t_result r;
        logic    frame_done;
        r = '0;
        if (hdr_taken < HEADER_BYTES) begin
            if (hdr_taken < LENGTH_BYTES) begin
                len_shift = {len_shift[23:0], b};
            end else if (hdr_taken < SECONDS_END) begin
                sec_shift = {sec_shift[55:0], b};
            end else begin
                nsec_shift = {nsec_shift[55:0], b};
            end
            hdr_taken = hdr_taken + 5'd1;
            if (hdr_taken == HEADER_BYTES) begin
                body_taken          = '0;
                r.frame_length      = len_shift;
                r.stamp_seconds     = sec_shift;
                r.stamp_nanoseconds = nsec_shift;
                if (len_shift > {16'd0, limit_len}) begin
                    // Oversize: flag it, then swallow the declared bytes
                    dropping = 1'b1;
                    r.kind   = KIND_ERROR;
                end else begin
                    dropping = 1'b0;
                    r.kind   = KIND_HEADER;
                    if (len_shift == '0) begin
                        hdr_taken       = '0;
                        r.last_of_frame = 1'b1;
                    end
                end
                expected_results.push_back(r);
            end
        end else begin
            body_taken = body_taken + 32'd1;
            frame_done = (body_taken >= len_shift);
            if (!dropping) begin
                r.kind              = KIND_PAYLOAD;
                r.frame_length      = len_shift;
                r.stamp_seconds     = sec_shift;
                r.stamp_nanoseconds = nsec_shift;
                r.data_byte         = b;
                r.last_of_frame     = frame_done;
                expected_results.push_back(r);
            end
            if (frame_done) begin
                hdr_taken = '0;
                dropping  = 1'b0;
            end
        end
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
            end
        end
    endfunction

    // Compare result items first, then predict from the byte taken at this edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            limit_len  = MAX_LENGTH_RESET;
            hdr_taken  = '0;
            len_shift  = '0;
            sec_shift  = '0;
            nsec_shift = '0;
            body_taken = '0;
            dropping   = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                limit_len = i_cfg_data;
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected result item: kind %0d length %h data %h",
                                 $time, i_kind, i_frame_length, i_data_byte);
                    end
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 64'(want.kind), 64'(i_kind));
                    check_field("frame_length", 64'(want.frame_length), 64'(i_frame_length));
                    check_field("stamp_seconds", want.stamp_seconds, i_stamp_seconds);
                    check_field("stamp_nanoseconds", want.stamp_nanoseconds,
                                i_stamp_nanoseconds);
                    check_field("data_byte", 64'(want.data_byte), 64'(i_data_byte));
                    check_field("last_of_frame", 64'(want.last_of_frame),
                                64'(i_last_of_frame));
                end
            end
            if (i_rx_valid && i_rx_ready) begin
                deframe_byte(i_rx_byte);
            end
        end
        o_pending     <= expected_results.size();
        o_error_count <= error_count;
    end

endmodule

@@ dv/tb_top.sv @@
// Top of the deframer testbench: clock, reset, byte stimulus, receiver stalls and verdict.
module tb_top import lpd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS    = 1000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int END_CYCLES      = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_data  = '0;
    logic        i_rx_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = '0;
    logic        i_res_ready = 1'b0;

    logic        o_rx_ready;
    logic        o_res_valid;
    logic [1:0]  o_kind;
    logic [31:0] o_frame_length;
    logic [63:0] o_stamp_seconds;
    logic [63:0] o_stamp_nanoseconds;
    logic [7:0]  o_data_byte;
    logic        o_last_of_frame;

    int mismatches;
    int pending;

    logic [7:0]  link_bytes[$];
    logic [15:0] cur_limit    = MAX_LENGTH_RESET;
    int          bytes_sent   = 0;
    bit          steady_mode  = 1'b0;
    bit          hold_off_req = 1'b0;
    int          quiet_cycles = 0;

    length_prefixed_deframer_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_rx_valid          (i_rx_valid),
        .o_rx_ready          (o_rx_ready),
        .i_rx_byte           (i_rx_byte),
        .o_res_valid         (o_res_valid),
        .i_res_ready         (i_res_ready),
        .o_kind              (o_kind),
        .o_frame_length      (o_frame_length),
        .o_stamp_seconds     (o_stamp_seconds),
        .o_stamp_nanoseconds (o_stamp_nanoseconds),
        .o_data_byte         (o_data_byte),
        .o_last_of_frame     (o_last_of_frame)
    );

    lpd_tb_checker u_tb_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_rx_valid          (i_rx_valid),
        .i_rx_ready          (o_rx_ready),
        .i_rx_byte           (i_rx_byte),
        .i_res_valid         (o_res_valid),
        .i_res_ready         (i_res_ready),
        .i_kind              (o_kind),
        .i_frame_length      (o_frame_length),
        .i_stamp_seconds     (o_stamp_seconds),
        .i_stamp_nanoseconds (o_stamp_nanoseconds),
        .i_data_byte         (o_data_byte),
        .i_last_of_frame     (o_last_of_frame),
        .o_error_count       (mismatches),
        .o_pending           (pending)
    );

    always #5 i_clk = ~i_clk;

    // Gap length for either side: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady_mode || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] pick_stamp();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return {$urandom, $urandom};
    endfunction

    // Payload length for the current limit: empty, boundary, oversize or typical
    function automatic logic [31:0] pick_length();
        int r;
        int cap;
        r   = $urandom_range(0, 9);
        cap = (cur_limit > 30) ? 30 : int'(cur_limit);
        if (r == 0) begin
            return '0;
        end else if (r <= 2 && cur_limit < 200) begin
            return 32'(cur_limit) + 32'($urandom_range(1, 7));
        end else if (r == 3 && cur_limit <= 40) begin
            return 32'(cur_limit);
        end
        return 32'($urandom_range(0, cap));
    endfunction

    // Queue one frame: header big endian, then the declared number of bytes
    task automatic add_frame(input logic [31:0] len, input logic [63:0] sec,
                             input logic [63:0] nsec);
        for (int i = 3; i >= 0; i--) link_bytes.push_back(len[8*i +: 8]);
        for (int i = 7; i >= 0; i--) link_bytes.push_back(sec[8*i +: 8]);
        for (int i = 7; i >= 0; i--) link_bytes.push_back(nsec[8*i +: 8]);
        for (int i = 0; i < int'(len); i++) link_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Offer one byte and hold it until taken, then maybe idle
    task automatic send_byte(input logic [7:0] b);
        int gap;
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        bytes_sent++;
        gap = idle_len();
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_bytes(input int count);
        repeat (count) send_byte(link_bytes.pop_front());
    endtask

    // Drain the block, then write the length limit
    task automatic set_limit(input logic [15:0] value);
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_limit  = value;
    endtask

    // Receiver: random ready runs, plus one long hold-off on request
    initial begin
        int high_run;
        int low_run;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_res_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            low_run = idle_len();
            if (low_run > 0) begin
                i_res_ready <= 1'b0;
                repeat (low_run) @(posedge i_clk);
            end
            i_res_ready <= 1'b1;
            high_run = $urandom_range(1, 20);
            repeat (high_run) @(posedge i_clk);
        end
    end

    // Stop the run when no item moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("length_prefixed_deframer_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int split;
        int r;
        logic [15:0] next_limit;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero length at the reset limit: header item is last, stamps all ones
        add_frame(32'd0, '1, '1);
        send_bytes(link_bytes.size());

        // Limit written mid-header applies to that header
        set_limit(16'd0);
        add_frame(32'd1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        send_bytes(8);
        set_limit(16'd1);
        send_bytes(link_bytes.size());

        // Oversize length: error item, payload dropped
        set_limit(16'd0);
        add_frame(32'd3, '0, '1);
        send_bytes(link_bytes.size());

        // Random frames across limits; the long receiver stall comes first
        hold_off_req = 1'b1;
        while (bytes_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                next_limit = 16'd0;
            end else if (r == 1) begin
                next_limit = 16'hffff;
            end else if (r == 2) begin
                next_limit = MAX_LENGTH_RESET;
            end else begin
                next_limit = 16'($urandom_range(1, 40));
            end
            set_limit(next_limit);
            steady_mode = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(3, 8)) add_frame(pick_length(), pick_stamp(), pick_stamp());
            // Sometimes change the limit partway through the stream
            split = link_bytes.size();
            if ($urandom_range(0, 2) == 0) begin
                split = $urandom_range(1, link_bytes.size() - 1);
            end
            send_bytes(split);
            if (link_bytes.size() != 0) begin
                set_limit(16'($urandom_range(0, 40)));
                send_bytes(link_bytes.size());
            end
        end
        steady_mode = 1'b0;

        // Widest limit, then a header whose length exceeds any limit
        set_limit(16'hffff);
        repeat (3) add_frame(pick_length(), pick_stamp(), pick_stamp());
        add_frame(32'd0, pick_stamp(), pick_stamp());
        send_bytes(link_bytes.size());
        for (int i = 0; i < 20; i++) begin
            link_bytes.push_back((i < 4) ? 8'hff : 8'($urandom_range(0, 255)));
        end
        repeat (3) link_bytes.push_back(8'($urandom_range(0, 255)));
        send_bytes(link_bytes.size());

        // Drain and give the verdict
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("length_prefixed_deframer_core verification clean");
        end else begin
            $display("length_prefixed_deframer_core verification failed");
        end
        $finish;
    end

endmodule

@@ length_prefixed_deframer_core.f @@
rtl/core/lpd_pkg.sv
rtl/core/lpd_in_reg.sv
rtl/core/lpd_parser.sv
rtl/core/lpd_out_reg.sv
rtl/core/length_prefixed_deframer_core.sv
rtl/core/lpd_checker.sv
dv/lpd_checker.sv
dv/tb_top.sv
